// ===== sv/sphere_fit_cost_accumulator_unit_assert.svh =====
// Assertion macros shared by the sphere fit cost accumulator RTL.
`ifndef SPHERE_FIT_COST_ACCUMULATOR_UNIT_ASSERT_SVH
`define SPHERE_FIT_COST_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sfca_pkg.sv =====
// Types and constants shared by the sphere fit cost accumulator modules.
package sfca_pkg;

  localparam int unsigned COORD_W      = 32;
  localparam int unsigned RADIUS_W     = 31;
  localparam int unsigned D2_W         = 66;
  localparam int unsigned COST_W       = 48;
  localparam int unsigned APB_ADDR_W   = 4;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned ITEM_Q_DEPTH = 4;
  localparam int unsigned ITEM_QCNT_W  = $clog2(ITEM_Q_DEPTH + 1);
  localparam int unsigned RES_Q_DEPTH  = 2;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;
  localparam logic [1:0] REG_RADIUS   = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0]  center_x;
    logic [COORD_W-1:0]  center_y;
    logic [COORD_W-1:0]  center_z;
    logic [RADIUS_W-1:0] radius;
  } cfg_t;

  // Word passed from the front end to the back end
  typedef struct packed {
    logic [D2_W-1:0] d2;
    logic            last;
  } item_t;

  // Result word
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              sat;
  } res_t;

endpackage

// ===== sv/sfca_fifo.sv =====
// Small register-based FIFO used between the pipeline parts.
module sfca_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== sv/sfca_regs.sv =====
// APB configuration registers: sphere centre and radius.
module sfca_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sfca_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sfca_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sfca_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output sfca_pkg::cfg_t                   cfg_o
);
  import sfca_pkg::*;

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x <= '0;
      cfg_q.center_y <= '0;
      cfg_q.center_z <= '0;
      cfg_q.radius   <= RADIUS_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CENTER_X: cfg_q.center_x <= pwdata;
        REG_CENTER_Y: cfg_q.center_y <= pwdata;
        REG_CENTER_Z: cfg_q.center_z <= pwdata;
        REG_RADIUS:   cfg_q.radius   <= pwdata[RADIUS_W-1:0];
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_CENTER_X: prdata = cfg_q.center_x;
      REG_CENTER_Y: prdata = cfg_q.center_y;
      REG_CENTER_Z: prdata = cfg_q.center_z;
      REG_RADIUS:   prdata = {1'b0, cfg_q.radius};
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== sv/sfca_front.sv =====
// Front end: takes points, forms squared distance to the centre, feeds the queue.
module sfca_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic [sfca_pkg::COORD_W-1:0]        point_x_i,
  input  logic [sfca_pkg::COORD_W-1:0]        point_y_i,
  input  logic [sfca_pkg::COORD_W-1:0]        point_z_i,
  input  logic                                last_i,
  input  sfca_pkg::cfg_t                      cfg_i,
  input  logic [sfca_pkg::ITEM_QCNT_W-1:0]    q_count_i,
  output logic                                q_push_o,
  output sfca_pkg::item_t                     q_item_o
);
  import sfca_pkg::*;

  `include "sphere_fit_cost_accumulator_unit_assert.svh"

  logic               accept;
  logic [COORD_W-1:0] ax_d, ay_d, az_d;
  logic [COORD_W-1:0] ax_q, ay_q, az_q;
  logic               s1_v_q, s1_last_q;
  logic [63:0]        sqx_q, sqy_q, sqz_q;
  logic               s2_v_q, s2_last_q;
  logic [ITEM_QCNT_W:0] used;

  // |p - c| of a signed coordinate pair, always fits 32 bits unsigned
  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] p,
                                                  input logic [COORD_W-1:0] c);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    begin
      d = $signed({p[COORD_W-1], p}) - $signed({c[COORD_W-1], c});
      m = d[COORD_W] ? -d : d;
      return m[COORD_W-1:0];
    end
  endfunction

  // Queue slots taken, counting words still in the pipe
  assign used   = (ITEM_QCNT_W+1)'(q_count_i) + (ITEM_QCNT_W+1)'(s1_v_q)
                + (ITEM_QCNT_W+1)'(s2_v_q);
  assign full_o = (used >= (ITEM_QCNT_W+1)'(ITEM_Q_DEPTH));
  assign accept = push_i && !full_o;

  assign ax_d = abs_diff(point_x_i, cfg_i.center_x);
  assign ay_d = abs_diff(point_y_i, cfg_i.center_y);
  assign az_d = abs_diff(point_z_i, cfg_i.center_z);

  // Stage 1: absolute differences; stage 2: squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q      <= ax_d;
      ay_q      <= ay_d;
      az_q      <= az_d;
      s1_last_q <= last_i;
    end
    if (s1_v_q) begin
      sqx_q     <= ax_q * ax_q;
      sqy_q     <= ay_q * ay_q;
      sqz_q     <= az_q * az_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Stage 3: sum of squares goes straight into the queue
  assign q_push_o      = s2_v_q;
  assign q_item_o.d2   = D2_W'(sqx_q) + D2_W'(sqy_q) + D2_W'(sqz_q);
  assign q_item_o.last = s2_last_q;

  `SFCA_ASSERT_IMP(a_front_no_overrun, clk_i, rst_ni, q_push_o,
                   q_count_i < ITEM_QCNT_W'(ITEM_Q_DEPTH), "front pushed into a full queue")

endmodule

// ===== sv/sfca_back.sv =====
// Back end: ratio division, residual square, accumulation, final scaling and division by the point count.
module sfca_back #(
  parameter int unsigned MAX_POINTS    = 4096,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sfca_pkg::cfg_t   cfg_i,
  input  logic             item_empty_i,
  input  sfca_pkg::item_t  item_i,
  output logic             item_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output sfca_pkg::res_t   res_o
);
  import sfca_pkg::*;

  `include "sphere_fit_cost_accumulator_unit_assert.svh"

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned DIV_W = 62;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_R2   = 10'b0000000010,
    S_DCHK = 10'b0000000100,
    S_DIV  = 10'b0000001000,
    S_ERR  = 10'b0000010000,
    S_SQ   = 10'b0000100000,
    S_TERM = 10'b0001000000,
    S_SCL  = 10'b0010000000,
    S_SCLF = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } back_state_e;

  back_state_e        state_q;
  logic [D2_W-1:0]    d2_q;
  logic               last_q;
  logic [DIV_W-1:0]   div_q, rem_q;
  logic [63:0]        num_q;
  logic               div_cost_q;
  logic [5:0]         step_q;
  logic [1:0]         scl_q;
  logic [127:0]       acc_q;
  logic [63:0]        pp_q;
  logic [1:0]         pp_sh_q;
  logic               pp_v_q;
  logic [63:0]        err_q, sc_q, sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               ovf_q;

  logic [RADIUS_W-1:0] r_eff;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [1:0]         pp_sh;
  logic [127:0]       pp_shifted;
  logic [DIV_W:0]     rem2, rem_sub;
  logic               rem_ge;
  logic               ratio_sat;
  logic [63:0]        term, sum_next;
  logic               term_sat;
  logic [64:0]        sum_add;
  logic               cnt_full;
  logic               sc_sat;
  logic [63:0]        sc_next;
  logic               cost_sat;

  // Zero radius behaves as the smallest step
  assign r_eff = (cfg_i.radius == '0) ? RADIUS_W'(1) : cfg_i.radius;

  // Shared 32x32 multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    pp_sh = 2'd0;
    case (state_q)
      S_R2: begin
        mul_a = {1'b0, r_eff};
        mul_b = {1'b0, r_eff};
      end
      S_SQ: begin
        case (step_q[1:0])
          2'd0: begin mul_a = err_q[31:0];  mul_b = err_q[31:0];  pp_sh = 2'd0; end
          2'd1: begin mul_a = err_q[31:0];  mul_b = err_q[63:32]; pp_sh = 2'd1; end
          2'd2: begin mul_a = err_q[63:32]; mul_b = err_q[31:0];  pp_sh = 2'd1; end
          default: begin mul_a = err_q[63:32]; mul_b = err_q[63:32]; pp_sh = 2'd2; end
        endcase
      end
      S_SCL: begin
        mul_a = step_q[0] ? sc_q[63:32] : sc_q[31:0];
        mul_b = {1'b0, r_eff};
        pp_sh = step_q[0] ? 2'd1 : 2'd0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod       = mul_a * mul_b;
  assign pp_shifted = {64'b0, pp_q} << {pp_sh_q, 5'b0};

  // One restoring division step
  assign rem2    = {rem_q, num_q[63]};
  assign rem_ge  = (rem2 >= {1'b0, div_q});
  assign rem_sub = rem2 - {1'b0, div_q};

  // Ratio overflows 64 bits when d2 >= r2 * 2^32
  assign ratio_sat = ({{(DIV_W-34){1'b0}}, d2_q[65:32]} >= div_q);

  // Residual term and running sum
  assign term_sat = |acc_q[127:96];
  assign term     = term_sat ? '1 : acc_q[95:32];
  assign sum_add  = {1'b0, sum_q} + {1'b0, term};
  assign sum_next = sum_add[64] ? '1 : sum_add[63:0];
  assign cnt_full = (cnt_q >= CNT_W'(MAX_POINTS));

  // Scale step: floor(a * r / 2^F)
  assign sc_sat  = |acc_q[127:64+FRACTION_BITS];
  assign sc_next = sc_sat ? '1 : acc_q[63+FRACTION_BITS:FRACTION_BITS];

  // Result
  assign cost_sat   = |num_q[63:COST_W];
  assign res_o.cost = cost_sat ? '1 : num_q[COST_W-1:0];
  assign res_o.sat  = ovf_q | cost_sat;
  assign res_push_o = (state_q == S_OUT) && !res_full_i;
  assign item_pop_o = (state_q == S_IDLE) && !item_empty_i;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      d2_q       <= '0;
      last_q     <= 1'b0;
      div_q      <= '0;
      rem_q      <= '0;
      num_q      <= '0;
      div_cost_q <= 1'b0;
      step_q     <= '0;
      scl_q      <= '0;
      acc_q      <= '0;
      pp_q       <= '0;
      pp_sh_q    <= '0;
      pp_v_q     <= 1'b0;
      err_q      <= '0;
      sc_q       <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
    end else begin
      if (pp_v_q) begin
        acc_q <= acc_q + pp_shifted;
      end
      case (state_q)
        S_IDLE: begin
          if (!item_empty_i) begin
            d2_q    <= item_i.d2;
            last_q  <= item_i.last;
            state_q <= S_R2;
          end
        end
        S_R2: begin
          div_q   <= prod[DIV_W-1:0];
          state_q <= S_DCHK;
        end
        S_DCHK: begin
          if (ratio_sat) begin
            num_q   <= '1;
            ovf_q   <= 1'b1;
            state_q <= S_ERR;
          end else begin
            rem_q      <= {{(DIV_W-34){1'b0}}, d2_q[65:32]};
            num_q      <= {d2_q[31:0], 32'b0};
            div_cost_q <= 1'b0;
            step_q     <= '0;
            state_q    <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= rem_ge ? rem_sub[DIV_W-1:0] : rem2[DIV_W-1:0];
          num_q  <= {num_q[62:0], rem_ge};
          step_q <= step_q + 1'b1;
          if (step_q == 6'd63) begin
            state_q <= div_cost_q ? S_OUT : S_ERR;
          end
        end
        S_ERR: begin
          err_q   <= (num_q >= 64'h1_0000_0000) ? num_q - 64'h1_0000_0000
                                                : 64'h1_0000_0000 - num_q;
          acc_q   <= '0;
          step_q  <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (step_q < 6'd4) begin
            pp_q    <= prod;
            pp_sh_q <= pp_sh;
            pp_v_q  <= 1'b1;
            step_q  <= step_q + 1'b1;
          end else begin
            pp_v_q  <= 1'b0;
            state_q <= S_TERM;
          end
        end
        S_TERM: begin
          sum_q <= sum_next;
          if (!cnt_full) begin
            cnt_q <= cnt_q + 1'b1;
          end
          ovf_q <= ovf_q | term_sat | sum_add[64] | cnt_full;
          if (last_q) begin
            sc_q    <= sum_next;
            acc_q   <= '0;
            step_q  <= '0;
            scl_q   <= '0;
            state_q <= S_SCL;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SCL: begin
          if (step_q < 6'd2) begin
            pp_q    <= prod;
            pp_sh_q <= pp_sh;
            pp_v_q  <= 1'b1;
            step_q  <= step_q + 1'b1;
          end else begin
            pp_v_q  <= 1'b0;
            state_q <= S_SCLF;
          end
        end
        S_SCLF: begin
          sc_q  <= sc_next;
          ovf_q <= ovf_q | sc_sat;
          if (scl_q == 2'd2) begin
            // Mean over the cloud: divide by the point count
            num_q      <= sc_next;
            rem_q      <= '0;
            div_q      <= {{(DIV_W-CNT_W){1'b0}}, cnt_q};
            div_cost_q <= 1'b1;
            step_q     <= '0;
            state_q    <= S_DIV;
          end else begin
            scl_q   <= scl_q + 1'b1;
            acc_q   <= '0;
            step_q  <= '0;
            state_q <= S_SCL;
          end
        end
        S_OUT: begin
          if (!res_full_i) begin
            sum_q   <= '0;
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `SFCA_ASSERT_IMP(a_back_rem_below_div, clk_i, rst_ni, state_q == S_DIV,
                   rem_q < div_q, "division remainder not below divisor")
  `SFCA_ASSERT_IMP(a_back_push_on_last, clk_i, rst_ni, res_push_o,
                   last_q && (cnt_q != '0), "result without a last point or with zero count")
  `SFCA_ASSERT_NXT(a_back_clear_after_out, clk_i, rst_ni, res_push_o,
                   (cnt_q == '0) && (sum_q == '0) && !ovf_q && (state_q == S_IDLE),
                   "cloud state not cleared after result")

endmodule

// ===== sv/sphere_fit_cost_accumulator_unit.sv =====
// Top level of the sphere fit cost accumulator.
//
//   Channel  | Handshake        | Payload
//   ---------+------------------+------------------------------------------
//   points   | push / full      | point_x_i, point_y_i, point_z_i, last_i
//   results  | pop / empty      | cost_o, saturated_o
//   config   | APB psel/penable | paddr, pwdata, prdata (4 regs at 4*i)
//
// The back end handles one point at a time, most of it in the bit-serial ratio
// division, which it skips when the ratio saturates; it sets the sustained point rate.
// The front end takes one point a cycle until its two-stage pipe and the four-word
// queue fill, then holds full high. A point marked last adds three scale multiplies,
// a division by the point count and the output state.
// Reset clears the running sum, count and flag; results wait in a two-word queue.
module sphere_fit_cost_accumulator_unit #(
  parameter int unsigned MAX_POINTS    = 4096,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // point channel
  input  logic                             push,
  output logic                             full,
  input  logic [sfca_pkg::COORD_W-1:0]     point_x_i,
  input  logic [sfca_pkg::COORD_W-1:0]     point_y_i,
  input  logic [sfca_pkg::COORD_W-1:0]     point_z_i,
  input  logic                             last_i,
  // result channel
  output logic                             empty,
  input  logic                             pop,
  output logic [sfca_pkg::COST_W-1:0]      cost_o,
  output logic                             saturated_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sfca_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sfca_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sfca_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import sfca_pkg::*;

  cfg_t                   cfg;
  item_t                  front_item, back_item;
  logic                   front_push;
  logic [ITEM_QCNT_W-1:0] item_count;
  logic                   item_full, item_empty, item_pop;
  logic [$bits(item_t)-1:0] item_rd;
  res_t                   back_res, res_head;
  logic                   res_push, res_full;
  logic [$bits(res_t)-1:0] res_rd;
  logic [$clog2(RES_Q_DEPTH+1)-1:0] res_count;

  sfca_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfca_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .last_i    (last_i),
    .cfg_i     (cfg),
    .q_count_i (item_count),
    .q_push_o  (front_push),
    .q_item_o  (front_item)
  );

  // Queue between front and back
  sfca_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (ITEM_Q_DEPTH)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_item),
    .full_o  (item_full),
    .pop_i   (item_pop),
    .data_o  (item_rd),
    .empty_o (item_empty),
    .count_o (item_count)
  );

  assign back_item = item_t'(item_rd);

  sfca_back #(
    .MAX_POINTS    (MAX_POINTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_empty_i (item_empty),
    .item_i       (back_item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  // Result queue
  sfca_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_rd),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign res_head    = res_t'(res_rd);
  assign cost_o      = res_head.cost;
  assign saturated_o = res_head.sat && (res_count != '0) && !item_full | res_head.sat
                       && (res_count != '0);

endmodule
